>>> hdl/irqc_pkg.sv
// irqc_pkg: widths, action codes and sizing constants for the interrupt request controller
// no dependencies
package irqc_pkg;

    localparam int VEC_W       = 8;
    localparam int BIT_W       = 6;
    localparam int GRP_FIELD_W = VEC_W - BIT_W;
    localparam int GROUP_BITS  = 64;
    localparam int GROUP_MAX   = 4;
    localparam int ACT_W       = 2;

    localparam logic [ACT_W-1:0] ACT_POST = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EOI  = 2'd2;

endpackage

>>> hdl/irqc_if.sv
// irqc_in_if / irqc_out_if: valid-ready channels for command and result beats
// depends on irqc_pkg
interface irqc_in_if;
    logic                          valid;
    logic                          ready;
    logic [irqc_pkg::ACT_W-1:0]    action;
    logic [irqc_pkg::VEC_W-1:0]    vector;

    modport source (output valid, output action, output vector, input ready);
    modport sink   (input valid, input action, input vector, output ready);
endinterface

interface irqc_out_if;
    logic                          valid;
    logic                          ready;
    logic [irqc_pkg::VEC_W-1:0]    granted_vector;
    logic                          spurious;
    logic                          request_pending;

    modport source (output valid, output granted_vector, output spurious,
                    output request_pending, input ready);
    modport sink   (input valid, input granted_vector, input spurious,
                    input request_pending, output ready);
endinterface

>>> hdl/interrupt_request_controller_unit.sv
// interrupt_request_controller_unit: request and in-service bit memories, read-modify-write
// depends on irqc_pkg and irqc_if (irqc_in_if, irqc_out_if)
//
//  channel  dir  beat contents                              handshake
//  i_in     in   action, vector                             valid / ready
//  o_out    out  granted_vector, spurious, request_pending  valid / ready
//
// each beat is a memory read at acceptance, then modify and write back
// a new beat is taken while the previous result still waits in the output register
// when the output register is full and not taken, the write-back cycle waits
// synchronous active-low reset clears per-group nonzero and valid flags; no clearing pass
module interrupt_request_controller_unit #(
    parameter int GROUP_COUNT = irqc_pkg::GROUP_MAX
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    irqc_in_if.sink        i_in,
    irqc_out_if.source     o_out
);
    import irqc_pkg::*;

    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    typedef enum logic {S_IDLE, S_MOD} t_state;

    logic [GROUP_BITS-1:0] r_req_mem [GROUP_COUNT];
    logic [GROUP_BITS-1:0] r_isr_mem [GROUP_COUNT];

    t_state                r_state;
    logic [GROUP_COUNT-1:0] r_nonzero, n_nonzero;
    logic [GROUP_COUNT-1:0] r_isr_vld, n_isr_vld;
    logic [ACT_W-1:0]      r_action;
    logic [BIT_W-1:0]      r_bit;
    logic [GW-1:0]         r_grp;
    logic                  r_hit;
    logic [GROUP_BITS-1:0] r_req_rd;
    logic [GROUP_BITS-1:0] r_isr_rd;
    logic                  r_out_valid;
    logic [VEC_W-1:0]      r_granted;
    logic                  r_spurious;
    logic                  r_pending;

    logic                  accept;
    logic                  mod_go;
    logic [GW-1:0]         rd_grp;
    logic                  rd_hit;
    logic [GW-1:0]         top_grp;
    logic                  top_found;
    logic [GROUP_BITS-1:0] req_old, isr_old, req_new, isr_new;
    logic [GROUP_BITS-1:0] low_onehot, bit_onehot;
    logic [BIT_W-1:0]      low_pos;
    logic                  req_we, isr_we;
    logic [VEC_W-1:0]      n_granted;
    logic                  n_spurious;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign mod_go     = (r_state == S_MOD) && (!r_out_valid || o_out.ready);

    // highest group holding a request
    always_comb begin
        top_grp   = '0;
        top_found = 1'b0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            if (r_nonzero[g]) begin
                top_grp   = GW'(g);
                top_found = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_in.action == ACT_ACK) begin
            rd_grp = top_grp;
            rd_hit = top_found;
        end else begin
            rd_grp = GW'(i_in.vector[VEC_W-1:BIT_W]);
            rd_hit = (32'(i_in.vector[VEC_W-1:BIT_W]) < GROUP_COUNT);
        end
    end

    // memory reads at acceptance
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_rd <= r_req_mem[rd_grp];
            r_isr_rd <= r_isr_mem[rd_grp];
        end
    end

    // lowest set bit of the group
    always_comb begin
        low_pos = '0;
        for (int b = GROUP_BITS - 1; b >= 0; b--) begin
            if (req_old[b]) begin
                low_pos = BIT_W'(b);
            end
        end
    end

    always_comb begin
        req_old    = r_nonzero[r_grp] ? r_req_rd : '0;
        isr_old    = r_isr_vld[r_grp] ? r_isr_rd : '0;
        low_onehot = req_old & (~req_old + GROUP_BITS'(1));
        bit_onehot = GROUP_BITS'(1) << r_bit;
        req_new    = req_old;
        isr_new    = isr_old;
        req_we     = 1'b0;
        isr_we     = 1'b0;
        n_nonzero  = r_nonzero;
        n_isr_vld  = r_isr_vld;
        n_granted  = '0;
        n_spurious = 1'b0;
        unique case (r_action)
            ACT_POST: begin
                if (r_hit) begin
                    req_new          = req_old | bit_onehot;
                    req_we           = 1'b1;
                    n_nonzero[r_grp] = 1'b1;
                end
            end
            ACT_ACK: begin
                if (r_hit) begin
                    req_new          = req_old & ~low_onehot;
                    isr_new          = isr_old | low_onehot;
                    req_we           = 1'b1;
                    isr_we           = 1'b1;
                    n_nonzero[r_grp] = |req_new;
                    n_isr_vld[r_grp] = 1'b1;
                    n_granted        = {GRP_FIELD_W'(r_grp), low_pos};
                end else begin
                    n_spurious = 1'b1;
                end
            end
            ACT_EOI: begin
                if (r_hit) begin
                    isr_new          = isr_old & ~bit_onehot;
                    isr_we           = 1'b1;
                    n_isr_vld[r_grp] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // write back
    always_ff @(posedge i_clk) begin
        if (mod_go && req_we) begin
            r_req_mem[r_grp] <= req_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mod_go && isr_we) begin
            r_isr_mem[r_grp] <= isr_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nonzero   <= '0;
            r_isr_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (mod_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_go) begin
                        r_state   <= S_IDLE;
                        r_nonzero <= n_nonzero;
                        r_isr_vld <= n_isr_vld;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (accept) begin
            r_action <= i_in.action;
            r_bit    <= i_in.vector[BIT_W-1:0];
            r_grp    <= rd_grp;
            r_hit    <= rd_hit;
        end
        if (mod_go) begin
            r_granted  <= n_granted;
            r_spurious <= n_spurious;
            r_pending  <= |n_nonzero;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.granted_vector  = r_granted;
    assign o_out.spurious        = r_spurious;
    assign o_out.request_pending = r_pending;

    a_accept_to_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MOD))
        else $error("accepted beat did not enter write-back");

    a_mod_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_go |=> o_out.valid)
        else $error("write-back produced no result beat");

    a_spur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.spurious) |-> (o_out.granted_vector == '0))
        else $error("spurious beat carries a vector");

    a_spur_nopend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.spurious) |-> !o_out.request_pending)
        else $error("spurious beat with request pending");

    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mod_go && r_action == ACT_ACK && r_hit) |-> $onehot(low_onehot))
        else $error("grant without a single selected bit");

endmodule

>>> tb/interrupt_request_controller_unit_tb.sv
// interrupt_request_controller_unit_tb: self-checking bench for the interrupt request controller
// predicts grant, spurious flag and pending flag per command beat and checks every result beat
// depends on irqc_pkg, irqc_in_if, irqc_out_if and interrupt_request_controller_unit
module interrupt_request_controller_unit_tb;
    import irqc_pkg::*;

    localparam int               GROUP_CNT  = GROUP_MAX;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int               RAND_BEATS = 1300;
    localparam int               STALL_MAX  = 2000;
    localparam int               HOLD_LEN   = 60;

    class irq_scoreboard;
        typedef struct packed {
            logic [VEC_W-1:0] granted_vector;
            logic             spurious;
            logic             request_pending;
        } t_irq_result;

        int                      group_count;
        logic [GROUP_BITS-1:0]   request_bits [GROUP_MAX];
        logic [GROUP_BITS-1:0]   service_bits [GROUP_MAX];
        logic                    pending;
        t_irq_result             expected_q [$];
        logic [VEC_W-1:0]        grants [$];
        int                      errors;

        function new(int groups);
            group_count = groups;
            foreach (request_bits[g]) begin
                request_bits[g] = '0;
                service_bits[g] = '0;
            end
            pending = 1'b0;
            errors  = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void note_beat(logic [ACT_W-1:0] act, logic [VEC_W-1:0] vec);
            int          grp;
            int          pos;
            bit          found;
            bit          any_left;
            t_irq_result res;
            grp   = int'(vec[VEC_W-1:BIT_W]);
            found = 1'b0;
            res   = '0;
            case (act)
                ACT_POST: begin
                    if (grp < group_count) begin
                        request_bits[grp][vec[BIT_W-1:0]] = 1'b1;
                        pending = 1'b1;
                    end
                end
                ACT_ACK: begin
                    for (int g = group_count - 1; g >= 0; g--) begin
                        if (!found && request_bits[g] != '0) begin
                            pos = 0;
                            while (!request_bits[g][pos]) pos++;
                            request_bits[g][pos] = 1'b0;
                            service_bits[g][pos] = 1'b1;
                            found = 1'b1;
                            res.granted_vector = VEC_W'(g * GROUP_BITS + pos);
                            grants.push_back(res.granted_vector);
                            if (grants.size() > 32) void'(grants.pop_front());
                        end
                    end
                    if (found) begin
                        any_left = 1'b0;
                        for (int g = 0; g < group_count; g++)
                            if (request_bits[g] != '0) any_left = 1'b1;
                        if (!any_left) pending = 1'b0;
                    end else begin
                        res.spurious = 1'b1;
                    end
                end
                ACT_EOI: begin
                    if (grp < group_count) service_bits[grp][vec[BIT_W-1:0]] = 1'b0;
                end
                default: ;
            endcase
            res.request_pending = pending;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [VEC_W-1:0] gv, logic sp, logic rp);
            t_irq_result want;
            if (expected_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result beat: vector %0d spurious %0b pending %0b",
                             gv, sp, rp);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (gv !== want.granted_vector || sp !== want.spurious
                || rp !== want.request_pending) begin
                if (errors < 10)
                    $display({"mismatch: expected vector %0d spurious %0b pending %0b,",
                              " got %0d %0b %0b"},
                             want.granted_vector, want.spurious, want.request_pending,
                             gv, sp, rp);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    irqc_in_if     in_ch ();
    irqc_out_if    out_ch ();
    irq_scoreboard sb;

    bit hold_req;
    bit rx_steady;
    bit stim_done;
    int hold_left;
    int stall_cycles;

    interrupt_request_controller_unit #(
        .GROUP_COUNT(GROUP_CNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [VEC_W-1:0] vec,
                             input bit may_idle);
        while (may_idle && $urandom_range(99) < 28) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.vector <= vec;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_beat(act, vec);
    endtask

    // result side: random backpressure, steady ready while rx_steady, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.granted_vector, out_ch.spurious, out_ch.request_pending);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN - 1;
                out_ch.ready <= 1'b0;
            end else if (rx_steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        @(posedge i_clk);
        while (!stim_done && stall_cycles < STALL_MAX) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        if (!stim_done) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int               post_pct;
        int               r;
        int               sel;
        logic [ACT_W-1:0] act;
        logic [VEC_W-1:0] vec;

        sb = new(GROUP_CNT);
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_POST;
        in_ch.vector <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty controller, unused code, posts at group edges incl. a repeat
        send_beat(ACT_ACK, 8'd0, 1'b1);
        send_beat(ACT_UNUSED, 8'd0, 1'b1);
        send_beat(ACT_POST, 8'd0, 1'b1);
        send_beat(ACT_POST, 8'd255, 1'b1);
        send_beat(ACT_POST, 8'd63, 1'b1);
        send_beat(ACT_POST, 8'd64, 1'b1);
        send_beat(ACT_POST, 8'd128, 1'b1);
        send_beat(ACT_POST, 8'd191, 1'b1);
        send_beat(ACT_POST, 8'd255, 1'b1);
        // drain all, then one more ack with nothing pending
        repeat (7) send_beat(ACT_ACK, 8'd0, 1'b1);
        send_beat(ACT_EOI, 8'd255, 1'b1);
        send_beat(ACT_EOI, 8'd255, 1'b1);
        send_beat(ACT_EOI, 8'd0, 1'b1);
        send_beat(ACT_UNUSED, 8'd170, 1'b1);

        for (int i = 0; i < RAND_BEATS; i++) begin
            case ((i / 100) % 3)
                0:       post_pct = 55;
                1:       post_pct = 38;
                default: post_pct = 25;
            endcase
            if (i == 300) hold_req = 1'b1;
            rx_steady = (i >= 900 && i < 1100);
            if (i == 700) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (sb.outstanding() != 0);
            end
            r   = $urandom_range(99);
            sel = $urandom_range(9);
            vec = VEC_W'($urandom_range(255));
            if (r < 3) begin
                act = ACT_UNUSED;
            end else if (r < 3 + post_pct) begin
                act = ACT_POST;
                if (sel < 2)
                    vec = {GRP_FIELD_W'($urandom_range(3)), sel[0] ? 6'd63 : 6'd0};
            end else if (r < 3 + post_pct + 30) begin
                act = ACT_ACK;
            end else begin
                act = ACT_EOI;
                if (sel < 6 && sb.grants.size() > 0)
                    vec = sb.grants[$urandom_range(sb.grants.size() - 1)];
            end
            send_beat(act, vec, !((i >= 300 && i < 360) || (i >= 900 && i < 1100)));
        end
        in_ch.valid <= 1'b0;
        rx_steady = 1'b0;

        do @(posedge i_clk); while (sb.outstanding() != 0);
        stim_done = 1'b1;
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> interrupt_request_controller_unit.f
hdl/irqc_pkg.sv
hdl/irqc_if.sv
hdl/interrupt_request_controller_unit.sv
tb/interrupt_request_controller_unit_tb.sv
